// ----- hdl/rlge_pkg.sv -----
// Shared types and constants of the run/literal group encoder.
// Used by every module in hdl/; depends on nothing.
package rlge_pkg;

  localparam int MAX_LITERAL = 32;
  localparam int MAX_RUN     = 255;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_LITERAL = 2'd1,
    KIND_REPEAT  = 2'd2
  } group_kind_e;

  typedef struct packed {
    logic signed [31:0] word_value;
    logic               last_word;
  } in_beat_t;

  typedef struct packed {
    group_kind_e        group_kind;
    logic [7:0]         group_count;
    logic signed [31:0] group_value;
    logic               last_result;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic cap_in;       // latch the accepted beat
    logic hold_load;    // held word := input word, run := 1
    logic run_inc;      // extend open run
    logic run_set2;     // lone held word becomes a run of two
    logic buf_write;    // push held word into the literal store
    logic emit_rep;     // load a repeat result
    logic emit_hdr;     // load a literal header
    logic emit_lit;     // load the next buffered literal
    logic clear_state;  // end of sequence
    logic final_phase;  // results now belong to the last step of the item
  } rlge_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic held_valid;
    logic run_ge2;
    logic word_eq;
    logic run_lt_max;
    logic fill_zero;
    logic fill_full_next;
    logic lit_end;
    logic in_last;
    logic out_free;
  } rlge_status_t;

endpackage

// ----- hdl/run_literal_group_encoder_core.sv -----
// Top level of the run/literal group encoder: controller plus datapath.
// Depends on rlge_pkg, rlge_ctrl and rlge_datapath.
//
// Usage
//   Input channel (in_valid_i/in_ready_o/in_data_i): one signed 32-bit word
//   per beat, last_word set on the final word of a sequence.
//   Output channel (out_valid_o/out_ready_i/out_data_o): one result per beat:
//   literal header (count), literal word (value) or repeat group
//   (count, value). last_result marks the final result of an input beat.
//   Sequencing
//   A word that produces no result or a single repeat is accepted and then
//   decided in S_DECIDE; last_word adds the closing step in S_TAIL.
//   A literal flush emits the header and then one result per buffered
//   word, read from the literal store one entry ahead of the output. Input
//   is held off (in_ready_o low) while any of this runs.
//   Stalls
//   The output register frees while the next word is decided; while the
//   receiver holds out_ready_i low, the sequencer waits on each result.
//   Reset
//   Asynchronous, active low: returns to idle with no held word, no open
//   run and an empty literal store. No clearing pass is needed.
module run_literal_group_encoder_core #(
  parameter int MaxLiteral = rlge_pkg::MAX_LITERAL,
  parameter int MaxRun     = rlge_pkg::MAX_RUN
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rlge_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rlge_pkg::out_beat_t out_data_o
);

  rlge_pkg::rlge_cmd_t    cmd;
  rlge_pkg::rlge_status_t status;

  // sequences one word: decision, optional flush, optional end-of-sequence
  rlge_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // holds the run state, the literal store and the output register
  rlge_datapath #(
    .MaxLiteral (MaxLiteral),
    .MaxRun     (MaxRun)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hdl/rlge_datapath.sv -----
// Datapath: held word, run counter, literal store memory, output register.
// Depends on rlge_pkg; driven by rlge_ctrl.
module rlge_datapath #(
  parameter int MaxLiteral = rlge_pkg::MAX_LITERAL,
  parameter int MaxRun     = rlge_pkg::MAX_RUN
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rlge_pkg::in_beat_t   in_data_i,
  input  rlge_pkg::rlge_cmd_t  cmd_i,
  output rlge_pkg::rlge_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rlge_pkg::out_beat_t  out_data_o
);

  localparam int FillW = $clog2(MaxLiteral + 1);
  localparam int IdxW  = $clog2(MaxLiteral);

  logic signed [31:0] word_q;
  logic               last_q;
  logic signed [31:0] held_q, held_d;
  logic               held_valid_q, held_valid_d;
  logic [7:0]         run_q, run_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [FillW-1:0]   ptr_q, ptr_d;
  logic [FillW-1:0]   rd_next;
  logic [IdxW-1:0]    rd_idx;
  logic signed [31:0] mem [MaxLiteral];
  logic signed [31:0] rd_q;
  logic               out_valid_q, out_valid_d;
  rlge_pkg::out_beat_t out_q, out_d;
  logic               lit_end;

  assign lit_end = (ptr_q == fill_q - FillW'(1));

  assign status_o.held_valid     = held_valid_q;
  assign status_o.run_ge2        = (run_q >= 8'd2);
  assign status_o.word_eq        = (word_q == held_q);
  assign status_o.run_lt_max     = (run_q < 8'(MaxRun));
  assign status_o.fill_zero      = (fill_q == '0);
  assign status_o.fill_full_next = (fill_q == FillW'(MaxLiteral - 1));
  assign status_o.lit_end        = lit_end;
  assign status_o.in_last        = last_q;
  assign status_o.out_free       = !out_valid_q || out_ready_i;

  // input beat capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      word_q <= in_data_i.word_value;
      last_q <= in_data_i.last_word;
    end
  end

  always_comb begin
    held_d       = held_q;
    held_valid_d = held_valid_q;
    run_d        = run_q;
    fill_d       = fill_q;
    ptr_d        = ptr_q;
    if (cmd_i.hold_load) begin
      held_d       = word_q;
      held_valid_d = 1'b1;
      run_d        = 8'd1;
    end
    if (cmd_i.run_inc)   run_d  = run_q + 8'd1;
    if (cmd_i.run_set2)  run_d  = 8'd2;
    if (cmd_i.buf_write) fill_d = fill_q + FillW'(1);
    if (cmd_i.emit_lit) begin
      if (lit_end) begin
        ptr_d  = '0;
        fill_d = '0;
      end else begin
        ptr_d = ptr_q + FillW'(1);
      end
    end
    if (cmd_i.clear_state) begin
      held_d       = '0;
      held_valid_d = 1'b0;
      run_d        = '0;
      fill_d       = '0;
      ptr_d        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= '0;
      held_valid_q <= 1'b0;
      run_q        <= '0;
      fill_q       <= '0;
      ptr_q        <= '0;
    end else begin
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      run_q        <= run_d;
      fill_q       <= fill_d;
      ptr_q        <= ptr_d;
    end
  end

  // literal store: one write, one registered read that runs one entry ahead
  always_comb begin
    rd_next = cmd_i.emit_lit ? ptr_q + FillW'(1) : ptr_q;
    if (rd_next >= FillW'(MaxLiteral)) rd_next = '0;
    rd_idx = rd_next[IdxW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_write) mem[fill_q[IdxW-1:0]] <= held_q;
    rd_q <= mem[rd_idx];
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.emit_rep) begin
      out_d.group_kind  = rlge_pkg::KIND_REPEAT;
      out_d.group_count = run_q;
      out_d.group_value = held_q;
      out_d.last_result = cmd_i.final_phase;
      out_valid_d       = 1'b1;
    end else if (cmd_i.emit_hdr) begin
      out_d.group_kind  = rlge_pkg::KIND_HEADER;
      out_d.group_count = 8'(fill_q);
      out_d.group_value = '0;
      out_d.last_result = 1'b0;
      out_valid_d       = 1'b1;
    end else if (cmd_i.emit_lit) begin
      out_d.group_kind  = rlge_pkg::KIND_LITERAL;
      out_d.group_count = '0;
      out_d.group_value = rd_q;
      out_d.last_result = cmd_i.final_phase && lit_end;
      out_valid_d       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/rlge_ctrl.sv -----
// Controller state machine of the run/literal group encoder.
// Depends on rlge_pkg; commands rlge_datapath.
module rlge_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rlge_pkg::rlge_status_t status_i,
  output rlge_pkg::rlge_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_HDR    = 3'd2;
  localparam logic [2:0] S_LIT    = 3'd3;
  localparam logic [2:0] S_TAIL   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       tail_q, tail_d;
  logic [2:0] after_step;

  // after the per-word step: end-of-sequence work, or done
  assign after_step = status_i.in_last ? S_TAIL : S_IDLE;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    tail_d  = tail_q;
    cmd_o   = '0;
    cmd_o.final_phase = tail_q || (state_q == S_TAIL) || !status_i.in_last;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          tail_d       = 1'b0;
          state_d      = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!status_i.held_valid) begin
          cmd_o.hold_load = 1'b1;
          state_d         = after_step;
        end else if (status_i.run_ge2) begin
          if (status_i.word_eq && status_i.run_lt_max) begin
            cmd_o.run_inc = 1'b1;
            state_d       = after_step;
          end else if (status_i.out_free) begin
            cmd_o.emit_rep  = 1'b1;
            cmd_o.hold_load = 1'b1;
            state_d         = after_step;
          end
        end else if (status_i.word_eq) begin
          cmd_o.run_set2 = 1'b1;
          state_d        = status_i.fill_zero ? after_step : S_HDR;
        end else begin
          cmd_o.buf_write = 1'b1;
          cmd_o.hold_load = 1'b1;
          state_d         = status_i.fill_full_next ? S_HDR : after_step;
        end
      end
      S_HDR: begin
        if (status_i.out_free) begin
          cmd_o.emit_hdr = 1'b1;
          state_d        = S_LIT;
        end
      end
      S_LIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_lit = 1'b1;
          if (status_i.lit_end) begin
            if (tail_q) begin
              cmd_o.clear_state = 1'b1;
              state_d           = S_IDLE;
            end else begin
              state_d = after_step;
            end
          end
        end
      end
      S_TAIL: begin
        tail_d = 1'b1;
        if (status_i.run_ge2) begin
          if (status_i.out_free) begin
            cmd_o.emit_rep    = 1'b1;
            cmd_o.clear_state = 1'b1;
            state_d           = S_IDLE;
          end
        end else begin
          // lone held word joins the literals; the group always flushes
          cmd_o.buf_write = 1'b1;
          state_d         = S_HDR;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tail_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tail_q  <= tail_d;
    end
  end

endmodule

// ----- hdl/rlge_checker.sv -----
// Port-level checks for run_literal_group_encoder_core, bound to the top.
// Depends on rlge_pkg.
module rlge_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rlge_pkg::out_beat_t out_data_o
);

  // output beat holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed under stall");

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted back to back");

  a_repeat_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.group_kind == rlge_pkg::KIND_REPEAT
      |-> out_data_o.group_count >= 8'd2)
    else $error("repeat group shorter than two words");

  a_header_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.group_kind == rlge_pkg::KIND_HEADER
      |-> out_data_o.group_count != 8'd0 && out_data_o.group_value == 32'sd0
          && !out_data_o.last_result)
    else $error("malformed literal header");

endmodule

bind run_literal_group_encoder_core rlge_checker u_rlge_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
